// ===== design/rdf_pkg.sv =====
// rdf_pkg: shared types and constants of the distance histogram block
// no dependencies; used by every module and the top level
`timescale 1ns / 1ps

package rdf_pkg;

  // width of a pair slot index (type pair or read-back pair)
  localparam int SLOT_W = 8;
  // entries of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_PAIR  = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic {
    KIND_COORD = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_BIN_WIDTH = 1'b0,
    REG_PARTIAL   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] distance_sq;
    logic [1:0]  center_type;
    logic [1:0]  neighbor_type;
    logic [3:0]  read_pair;
    logic [5:0]  read_bin;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] coordination;
    logic [31:0] total_count;
    logic [31:0] pair_count;
  } out_word_t;

  typedef struct packed {
    logic [15:0] bin_width;
    logic        partial_enable;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e               op;
    logic [31:0]       dsq;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic [5:0]        bin;
    logic              bin_ok;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

// ===== design/rdf_stream_if.sv =====
// rdf_stream_if: valid/ready channel carrying one word of type T
// no package dependency; the word type T is a parameter
`timescale 1ns / 1ps

interface rdf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/rdf_front.sv =====
// rdf_front: accepts input words and classifies them into back-end commands
// depends on rdf_pkg and rdf_stream_if
`timescale 1ns / 1ps

module rdf_front #(
  parameter int BINS      = 64,
  parameter int NUM_TYPES = 4
) (
  rdf_stream_if.sink          in_i,
  input  rdf_pkg::cfg_t        cfg_i,
  input  rdf_pkg::back_status_t status_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output rdf_pkg::cmd_t        cmd_o
);
  import rdf_pkg::*;

  logic [1:0] ta;
  logic [1:0] tb;

  assign in_i.ready = !q_full_i && !status_i.init_busy;
  assign push_o     = in_i.valid && in_i.ready;

  // ordered type pair (min, max)
  assign ta = (in_i.data.center_type < in_i.data.neighbor_type) ?
              in_i.data.center_type : in_i.data.neighbor_type;
  assign tb = (in_i.data.center_type < in_i.data.neighbor_type) ?
              in_i.data.neighbor_type : in_i.data.center_type;

  always_comb begin
    cmd_o.op     = op_e'(in_i.data.operation);
    cmd_o.dsq    = in_i.data.distance_sq;
    cmd_o.bin    = in_i.data.read_bin;
    cmd_o.bin_ok = int'(in_i.data.read_bin) < BINS;
    case (op_e'(in_i.data.operation))
      OP_PAIR: begin
        cmd_o.slot    = SLOT_W'(int'(ta) * NUM_TYPES + int'(tb));
        cmd_o.slot_ok = cfg_i.partial_enable && (int'(tb) < NUM_TYPES);
      end
      OP_READ: begin
        cmd_o.slot    = SLOT_W'(in_i.data.read_pair);
        cmd_o.slot_ok = int'(in_i.data.read_pair) < NUM_TYPES * NUM_TYPES;
      end
      default: begin
        cmd_o.slot    = '0;
        cmd_o.slot_ok = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/rdf_queue.sv =====
// rdf_queue: small command queue between front and back
// depends on rdf_pkg
`timescale 1ns / 1ps

module rdf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rdf_pkg::cmd_t data_i,
  input  logic          pop_i,
  output rdf_pkg::cmd_t data_o,
  output logic          empty_o,
  output logic          full_o
);
  import rdf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/rdf_back.sv =====
// rdf_back: bin search, histogram memories, coordination count, result register
// depends on rdf_pkg and rdf_stream_if
`timescale 1ns / 1ps

module rdf_back #(
  parameter int BINS      = 64,
  parameter int NUM_TYPES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rdf_pkg::cfg_t         cfg_i,
  input  rdf_pkg::cmd_t         cmd_i,
  input  logic                  q_empty_i,
  output logic                  pop_o,
  output rdf_pkg::back_status_t status_o,
  rdf_stream_if.source          out_o
);
  import rdf_pkg::*;

  localparam int KW     = $clog2(BINS + 1);
  localparam int BIT_W  = $clog2(KW);
  localparam int TAW    = $clog2(BINS);
  localparam int PDEPTH = NUM_TYPES * NUM_TYPES * BINS;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int BIW    = (KW > 6) ? KW : 6;
  localparam int PW     = KW + 16;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_SQR   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_WR    = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  cmd_t             cmd_q;
  logic [KW-1:0]    k_q, k_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic [PW-1:0]    prod_q;
  logic [15:0]      count_q, count_d;
  logic [15:0]      coord_q, coord_d;
  logic [PAW-1:0]   clr_q, clr_d;
  logic             init_q, init_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;
  logic [31:0]      tot_rd_q;
  logic [31:0]      pair_rd_q;

  logic [31:0]      total_mem [BINS];
  logic [31:0]      pair_mem [PDEPTH];

  logic [KW-1:0]    trial;
  logic [2*PW-1:0]  sq;
  logic             fits;
  logic [KW-1:0]    k_next;
  logic [BIW-1:0]   cur_bin;
  logic [TAW-1:0]   tot_addr;
  logic [PAW-1:0]   pair_addr;
  logic             tot_we;
  logic [TAW-1:0]   tot_wa;
  logic [31:0]      tot_wd;
  logic             pair_we;
  logic [PAW-1:0]   pair_wa;
  logic [31:0]      pair_wd;
  logic             out_free;

  assign pop_o              = (state_q == S_IDLE) && !q_empty_i;
  assign status_o.init_busy = init_q;
  assign out_o.valid        = out_valid_q;
  assign out_o.data         = out_q;
  assign out_free           = !out_valid_q || out_o.ready;

  // one result bit per trial: (trial * bin_width)^2 <= distance_sq
  assign trial  = k_q | (KW'(1) << bit_q);
  assign sq     = (2*PW)'(prod_q) * (2*PW)'(prod_q);
  assign fits   = sq <= (2*PW)'(cmd_q.dsq);
  assign k_next = fits ? trial : k_q;

  assign cur_bin   = (cmd_q.op == OP_READ) ? BIW'(cmd_q.bin) : BIW'(k_q);
  assign tot_addr  = cur_bin[TAW-1:0];
  assign pair_addr = PAW'(int'(cmd_q.slot) * BINS + int'(cur_bin));

  // write ports: clearing sweep or saturating increment
  always_comb begin
    tot_we  = 1'b0;
    tot_wa  = tot_addr;
    tot_wd  = (tot_rd_q == '1) ? tot_rd_q : tot_rd_q + 32'd1;
    pair_we = 1'b0;
    pair_wa = pair_addr;
    pair_wd = (pair_rd_q == '1) ? pair_rd_q : pair_rd_q + 32'd1;
    if (state_q == S_CLEAR) begin
      tot_we  = int'(clr_q) < BINS;
      tot_wa  = clr_q[TAW-1:0];
      tot_wd  = '0;
      pair_we = 1'b1;
      pair_wa = clr_q;
      pair_wd = '0;
    end else if (state_q == S_WR) begin
      tot_we  = 1'b1;
      pair_we = cmd_q.slot_ok;
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    bit_d       = bit_q;
    count_d     = count_q;
    coord_d     = coord_q;
    clr_d       = clr_q;
    init_d      = init_q;
    out_valid_d = (out_valid_q && out_o.ready) ? 1'b0 : out_valid_q;
    out_d       = out_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + PAW'(1);
        if (clr_q == PAW'(PDEPTH - 1)) begin
          clr_d   = '0;
          init_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          case (cmd_i.op)
            OP_PAIR: begin
              count_d = (count_q == '1) ? count_q : count_q + 16'd1;
              k_d     = '0;
              bit_d   = BIT_W'(KW - 1);
              state_d = S_MUL;
            end
            OP_END: begin
              coord_d = count_q;
              count_d = '0;
              state_d = S_EMIT;
            end
            OP_READ: begin
              state_d = S_RD;
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        state_d = S_SQR;
      end
      S_SQR: begin
        k_d = k_next;
        if (bit_q == '0) begin
          state_d = (int'(k_next) < BINS) ? S_RD : S_IDLE;
        end else begin
          bit_d   = bit_q - BIT_W'(1);
          state_d = S_MUL;
        end
      end
      S_RD: begin
        state_d = (cmd_q.op == OP_READ) ? S_EMIT : S_WR;
      end
      S_WR: begin
        state_d = S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (cmd_q.op == OP_END) begin
            out_d.result_kind  = KIND_COORD;
            out_d.coordination = coord_q;
            out_d.total_count  = '0;
            out_d.pair_count   = '0;
          end else begin
            out_d.result_kind  = KIND_READ;
            out_d.coordination = '0;
            out_d.total_count  = cmd_q.bin_ok ? tot_rd_q : '0;
            out_d.pair_count   = (cmd_q.bin_ok && cmd_q.slot_ok) ? pair_rd_q : '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      k_q         <= '0;
      bit_q       <= '0;
      count_q     <= '0;
      coord_q     <= '0;
      clr_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      bit_q       <= bit_d;
      count_q     <= count_d;
      coord_q     <= coord_d;
      clr_q       <= clr_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= PW'(trial) * PW'(cfg_i.bin_width);
    end
  end

  // histogram memories, registered read
  always_ff @(posedge clk_i) begin
    if (tot_we) begin
      total_mem[tot_wa] <= tot_wd;
    end
    if (state_q == S_RD) begin
      tot_rd_q <= total_mem[tot_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    if (state_q == S_RD) begin
      pair_rd_q <= pair_mem[pair_addr];
    end
  end

  a_init_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> state_q == S_CLEAR)
    else $error("initial clear left before the sweep ended");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> (int'(k_q) < BINS) && (cmd_q.op == OP_PAIR))
    else $error("histogram increment outside the bin range");

  a_count_restarted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && (cmd_q.op == OP_END) |-> count_q == '0)
    else $error("neighbor count not restarted at end of particle");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("result word raised outside the emit step");

endmodule

// ===== design/rdf_distance_histogram_top.sv =====
// rdf_distance_histogram_top: distance histogram with coordination counting
// neighbor pair: bin search over clog2(BINS+1) result bits, each a multiply then a square,
//   then histogram read and increment (skipped past the last bin); read bin: read then result
// throughput: one word at a time in the back end, two-entry queue ahead of it
// reset and clear item: histogram memories swept one entry per cycle,
//   all NUM_TYPES*NUM_TYPES*BINS pair entries (1024 by default); no input taken during reset sweep
`timescale 1ns / 1ps

module rdf_distance_histogram_top #(
  parameter int BINS      = 64,
  parameter int NUM_TYPES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rdf_stream_if.sink   in_i,
  rdf_stream_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rdf_pkg::*;

  // configuration registers
  logic [15:0]  bin_width_q;
  logic         partial_q;
  logic         cfg_wr;
  reg_e         reg_sel;
  cfg_t         cfg;

  // front to queue to back
  logic         push;
  cmd_t         push_cmd;
  cmd_t         head_cmd;
  logic         q_empty;
  logic         q_full;
  logic         pop;
  back_status_t back_status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  // registers sit 4 bytes apart, only paddr[2] selects
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= 16'd1;
      partial_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_BIN_WIDTH: begin
          bin_width_q <= pwdata[15:0];
        end
        REG_PARTIAL: begin
          partial_q <= pwdata[0];
        end
        default: begin
          partial_q <= partial_q;
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (reg_sel)
      REG_BIN_WIDTH: prdata = {16'd0, bin_width_q};
      REG_PARTIAL:   prdata = {31'd0, partial_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg.bin_width      = bin_width_q;
  assign cfg.partial_enable = partial_q;

  // front: takes a word, orders the type pair, checks slot and bin ranges
  rdf_front #(
    .BINS      (BINS),
    .NUM_TYPES (NUM_TYPES)
  ) u_front (
    .in_i     (in_i),
    .cfg_i    (cfg),
    .status_i (back_status),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // queue lets the front keep taking words while the back searches
  rdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: bin search, histogram update or read, result register
  rdf_back #(
    .BINS      (BINS),
    .NUM_TYPES (NUM_TYPES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (head_cmd),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .status_o  (back_status),
    .out_o     (out_o)
  );

endmodule
